### hw/rtl/bdp_pkg.sv
// ============================================================================
// bdp_pkg
// Shared types, constants and helpers for the branch direction predictor.
// ============================================================================
package bdp_pkg;

    // Table sizes default to powers of two; the memories index by low address bits.
    localparam int COUNTER_ENTRIES_DEF  = 4096;
    localparam int HISTORY_ENTRIES_DEF  = 1024;
    localparam int MAX_HISTORY_BITS_DEF = 8;

    localparam int PC_W        = 48;
    localparam int PC_IDX_W    = 10;  // widest pc index, index_bits saturates at ten
    localparam int GHIST_W     = 10;
    localparam int CTR_W       = 8;
    localparam int CTR_BITS_W  = 4;
    localparam int HB_W        = 5;
    localparam int IB_W        = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int COUNT_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [CTR_W-1:0]   CTR_RESET   = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [IB_W-1:0]    IB_MAX      = 4'd10;
    localparam logic [CTR_BITS_W-1:0] CB_MAX   = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 2'd0,
        REG_CTR_WIDTH  = 2'd1,
        REG_HIST_LEN   = 2'd2,
        REG_INDEX_BITS = 2'd3
    } bdp_reg_t;

    typedef enum logic [1:0] {
        MODE_BIMODAL   = 2'd0,
        MODE_TWO_LEVEL = 2'd1,
        MODE_LOCAL     = 2'd2,
        MODE_GSHARE    = 2'd3
    } bdp_mode_t;

    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [PC_W-1:0] pc;
        logic            actual_taken;
        logic            predicted_taken;
    } bdp_in_t;

    typedef struct packed {
        logic               prediction;
        logic [COUNT_W-1:0] branch_count;
        logic [COUNT_W-1:0] correct_count;
    } bdp_out_t;

    // Register values after saturation into their used ranges.
    typedef struct packed {
        bdp_mode_t             mode;
        logic [CTR_BITS_W-1:0] ctr_width;
        logic [HB_W-1:0]       hist_len;
        logic [IB_W-1:0]       index_bits;
    } bdp_cfg_t;

    // One queued item: the pc is already reduced to its masked index bits.
    typedef struct packed {
        logic                req_type;
        logic [PC_IDX_W-1:0] pc_idx;
        logic                actual_taken;
        logic                predicted_taken;
    } bdp_item_t;

    function automatic logic [PC_IDX_W-1:0] pc_low_mask(input logic [IB_W-1:0] ib);
        logic [PC_IDX_W:0] wide;
        wide = ((PC_IDX_W+1)'(1) << ib) - (PC_IDX_W+1)'(1);
        return wide[PC_IDX_W-1:0];
    endfunction

endpackage

### hw/rtl/bdp_front.sv
// ============================================================================
// bdp_front
// Input side: takes request transfers, reduces the pc to its table index and
// holds the items in a short queue for the back end.
// ============================================================================
module bdp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bdp_pkg::bdp_in_t     in_data,
    input  logic                 clearing,
    input  bdp_pkg::bdp_cfg_t    cfg,
    output logic                 item_valid,
    output bdp_pkg::bdp_item_t   item,
    input  logic                 pop
);
    import bdp_pkg::*;

    bdp_item_t              q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]      count_reg, count_next;
    logic                   push;
    logic                   do_pop;
    bdp_item_t              push_item;

    always_comb
    begin
        push_item.req_type        = in_data.req_type;
        push_item.pc_idx          = in_data.pc[PC_IDX_W-1:0] & pc_low_mask(cfg.index_bits);
        push_item.actual_taken    = in_data.actual_taken;
        push_item.predicted_taken = in_data.predicted_taken;
    end

    assign in_stall   = clearing || (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign item_valid = (count_reg != '0);
    assign do_pop     = pop && item_valid;
    assign item       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/bdp_back.sv
// ============================================================================
// bdp_back
// Execution side: owns the counter and history tables, looks up and updates
// them for one item at a time and drives the result register.
// ============================================================================
module bdp_back
#(
    parameter int COUNTER_ENTRIES  = bdp_pkg::COUNTER_ENTRIES_DEF,
    parameter int HISTORY_ENTRIES  = bdp_pkg::HISTORY_ENTRIES_DEF,
    parameter int MAX_HISTORY_BITS = bdp_pkg::MAX_HISTORY_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bdp_pkg::bdp_cfg_t    cfg,
    input  logic                 item_valid,
    input  bdp_pkg::bdp_item_t   item,
    output logic                 pop,
    output logic                 clearing,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bdp_pkg::bdp_out_t    out_data
);
    import bdp_pkg::*;

    localparam int CNT_AW = $clog2(COUNTER_ENTRIES);
    localparam int HIST_AW = $clog2(HISTORY_ENTRIES);
    localparam int HW = MAX_HISTORY_BITS;
    localparam int IDX_W = (PC_IDX_W + HW > CNT_AW) ? PC_IDX_W + HW : CNT_AW;
    localparam int HS_W = (PC_IDX_W > HIST_AW) ? PC_IDX_W : HIST_AW;
    localparam int CLR_N = (COUNTER_ENTRIES > HISTORY_ENTRIES) ? COUNTER_ENTRIES
                                                               : HISTORY_ENTRIES;
    localparam int CLR_AW = $clog2(CLR_N);
    localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_N - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CNT
    } state_t;

    logic [CTR_W-1:0]     cnt_mem [COUNTER_ENTRIES];
    logic [HW-1:0]        hist_mem [HISTORY_ENTRIES];

    state_t               state_reg;
    logic [CLR_AW-1:0]    clr_idx_reg;
    bdp_item_t            item_reg;
    logic [GHIST_W-1:0]   ghist_reg;
    logic [COUNT_W-1:0]   branches_reg;
    logic [COUNT_W-1:0]   correct_reg;
    logic                 out_valid_reg;
    bdp_out_t             out_data_reg;
    logic [HW-1:0]        hist_rdata_reg;
    logic [CTR_W-1:0]     cnt_rdata_reg;

    logic                 hist_rd_en;
    logic [HIST_AW-1:0]   hist_raddr;
    logic                 hist_we;
    logic [HIST_AW-1:0]   hist_waddr;
    logic [HW-1:0]        hist_wdata;
    logic                 cnt_rd_en;
    logic [CNT_AW-1:0]    cnt_raddr;
    logic                 cnt_we;
    logic [CNT_AW-1:0]    cnt_waddr;
    logic [CTR_W-1:0]     cnt_wdata;

    logic [HW:0]          hmask_wide;
    logic [HW-1:0]        hist_used;
    logic [IDX_W-1:0]     cidx_wide;
    logic [HIST_AW-1:0]   item_hist_addr;
    logic [HW:0]          hist_shifted;
    logic [CTR_W:0]       cmax_wide;
    logic [CTR_W-1:0]     cmax;
    logic [CTR_W-1:0]     half;
    logic [CTR_W-1:0]     ctr_updated;
    logic                 pred;
    logic                 finish;
    logic                 clr_in_cnt;
    logic                 clr_in_hist;

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = (state_reg == ST_IDLE) && item_valid;
    assign finish    = (state_reg == ST_CNT) && (!out_valid_reg || !out_stall);

    assign clr_in_cnt  = ({1'b0, clr_idx_reg} < (CLR_AW+1)'(COUNTER_ENTRIES));
    assign clr_in_hist = ({1'b0, clr_idx_reg} < (CLR_AW+1)'(HISTORY_ENTRIES));

    // History slot of the held item and of the item at the queue head.
    assign item_hist_addr = HIST_AW'(HS_W'(item_reg.pc_idx));
    assign hist_rd_en     = pop;
    assign hist_raddr     = HIST_AW'(HS_W'(item.pc_idx));

    // Counter index from the registered history entry of the held item.
    always_comb
    begin
        hmask_wide = ((HW+1)'(1) << cfg.hist_len) - (HW+1)'(1);
        hist_used  = hist_rdata_reg & hmask_wide[HW-1:0];
        unique case (cfg.mode)
            MODE_BIMODAL:   cidx_wide = IDX_W'(item_reg.pc_idx);
            MODE_TWO_LEVEL: cidx_wide = IDX_W'(hist_used);
            MODE_LOCAL:     cidx_wide = (IDX_W'(item_reg.pc_idx) << cfg.hist_len)
                                        + IDX_W'(hist_used);
            MODE_GSHARE:    cidx_wide = IDX_W'(item_reg.pc_idx
                                        ^ (ghist_reg & pc_low_mask(cfg.index_bits)));
            default:        cidx_wide = '0;
        endcase
    end

    assign cnt_rd_en = (state_reg == ST_HIST);
    assign cnt_raddr = CNT_AW'(cidx_wide);

    // Counter arithmetic on the value read for the held item.
    always_comb
    begin
        cmax_wide = ((CTR_W+1)'(1) << cfg.ctr_width) - (CTR_W+1)'(1);
        cmax      = cmax_wide[CTR_W-1:0];
        half      = CTR_W'(1) << (cfg.ctr_width - CTR_BITS_W'(1));
        pred      = (cnt_rdata_reg >= half);
        if (item_reg.actual_taken)
        begin
            ctr_updated = (cnt_rdata_reg < cmax) ? cnt_rdata_reg + CTR_W'(1) : cmax;
        end
        else
        begin
            ctr_updated = (cnt_rdata_reg != '0) ? cnt_rdata_reg - CTR_W'(1)
                                                : cnt_rdata_reg;
        end
        hist_shifted = {hist_rdata_reg, item_reg.actual_taken};
    end

    // Table write ports: the clearing sweep after reset, then item updates.
    always_comb
    begin
        cnt_we     = 1'b0;
        cnt_waddr  = CNT_AW'(clr_idx_reg);
        cnt_wdata  = CTR_RESET;
        hist_we    = 1'b0;
        hist_waddr = HIST_AW'(clr_idx_reg);
        hist_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            cnt_we  = clr_in_cnt;
            hist_we = clr_in_hist;
        end
        else if (finish && (item_reg.req_type == REQ_UPDATE))
        begin
            cnt_we     = 1'b1;
            cnt_waddr  = cnt_raddr;
            cnt_wdata  = ctr_updated;
            hist_we    = (cfg.mode == MODE_TWO_LEVEL) || (cfg.mode == MODE_LOCAL);
            hist_waddr = item_hist_addr;
            hist_wdata = hist_shifted[HW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_rd_en)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_rd_en)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            ghist_reg     <= '0;
            branches_reg  <= '0;
            correct_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // A result leaving in the same cycle as the next one is loaded stays valid.
            if (out_valid_reg && !out_stall && !finish)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + CLR_AW'(1);
                    if (clr_idx_reg == CLR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= ST_HIST;
                    end
                end
                ST_HIST:
                begin
                    state_reg <= ST_CNT;
                end
                ST_CNT:
                begin
                    if (finish)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        if (item_reg.req_type == REQ_PREDICT)
                        begin
                            out_data_reg.prediction    <= pred;
                            out_data_reg.branch_count  <= (branches_reg != COUNT_MAX)
                                                          ? branches_reg + COUNT_W'(1)
                                                          : branches_reg;
                            out_data_reg.correct_count <= correct_reg;
                            if (branches_reg != COUNT_MAX)
                            begin
                                branches_reg <= branches_reg + COUNT_W'(1);
                            end
                        end
                        else
                        begin
                            out_data_reg.prediction   <= 1'b0;
                            out_data_reg.branch_count <= branches_reg;
                            if ((item_reg.actual_taken == item_reg.predicted_taken)
                                && (correct_reg != COUNT_MAX))
                            begin
                                correct_reg                <= correct_reg + COUNT_W'(1);
                                out_data_reg.correct_count <= correct_reg + COUNT_W'(1);
                            end
                            else
                            begin
                                out_data_reg.correct_count <= correct_reg;
                            end
                            if (cfg.mode == MODE_GSHARE)
                            begin
                                ghist_reg <= {ghist_reg[GHIST_W-2:0], item_reg.actual_taken};
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/branch_direction_predictor.sv
// ============================================================================
// branch_direction_predictor
// Bimodal, two-level, local-history and gshare direction predictor sharing
// one table of saturating counters.
// ============================================================================
// Each request returns one result. The back end handles one request at a
// time: history table read, counter table read, then the counter and
// history write with the result register load, which waits while a held
// result is stalled. A two-entry queue in front keeps taking requests while
// the back end works or the result waits. After reset the tables are swept
// to their reset values, one entry per cycle, while in_stall stays high.
// Table sizes must be powers of two.
module branch_direction_predictor
#(
    parameter int COUNTER_ENTRIES  = bdp_pkg::COUNTER_ENTRIES_DEF,
    parameter int HISTORY_ENTRIES  = bdp_pkg::HISTORY_ENTRIES_DEF,
    parameter int MAX_HISTORY_BITS = bdp_pkg::MAX_HISTORY_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  bdp_pkg::bdp_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output bdp_pkg::bdp_out_t                 out_data,
    input  logic                              cfg_wr_en,
    input  logic [bdp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bdp_pkg::*;

    localparam logic [HB_W-1:0] HB_MAX = HB_W'(MAX_HISTORY_BITS);

    logic [1:0]            mode_reg;
    logic [CTR_BITS_W-1:0] ctr_width_reg;
    logic [3:0]            hist_len_reg;
    logic [IB_W-1:0]       index_bits_reg;
    bdp_cfg_t              cfg;
    logic                  clearing;
    logic                  item_valid;
    bdp_item_t             item;
    logic                  pop;
    logic [HB_W-1:0]       hb_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 2'd0;
            ctr_width_reg  <= 4'd2;
            hist_len_reg   <= 4'd2;
            index_bits_reg <= 4'd10;
        end
        else if (cfg_wr_en)
        begin
            unique case (bdp_reg_t'(cfg_index))
                REG_MODE:       mode_reg       <= cfg_wdata[1:0];
                REG_CTR_WIDTH:  ctr_width_reg  <= cfg_wdata;
                REG_HIST_LEN:   hist_len_reg   <= cfg_wdata;
                REG_INDEX_BITS: index_bits_reg <= cfg_wdata;
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    // Registers saturate into their used ranges; zero acts as one.
    always_comb
    begin
        hb_ext   = HB_W'(hist_len_reg);
        cfg.mode = bdp_mode_t'(mode_reg);
        if (ctr_width_reg == '0)
        begin
            cfg.ctr_width = CTR_BITS_W'(1);
        end
        else if (ctr_width_reg > CB_MAX)
        begin
            cfg.ctr_width = CB_MAX;
        end
        else
        begin
            cfg.ctr_width = ctr_width_reg;
        end
        if (hb_ext == '0)
        begin
            cfg.hist_len = HB_W'(1);
        end
        else if (hb_ext > HB_MAX)
        begin
            cfg.hist_len = HB_MAX;
        end
        else
        begin
            cfg.hist_len = hb_ext;
        end
        if (index_bits_reg == '0)
        begin
            cfg.index_bits = IB_W'(1);
        end
        else if (index_bits_reg > IB_MAX)
        begin
            cfg.index_bits = IB_MAX;
        end
        else
        begin
            cfg.index_bits = index_bits_reg;
        end
    end

    bdp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .clearing   (clearing),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    bdp_back
    #(
        .COUNTER_ENTRIES  (COUNTER_ENTRIES),
        .HISTORY_ENTRIES  (HISTORY_ENTRIES),
        .MAX_HISTORY_BITS (MAX_HISTORY_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

### verif/branch_direction_predictor_test.sv
// ============================================================================
// branch_direction_predictor_test
// Self-checking bench for the branch direction predictor. A behavioral model
// of the counter and history tables predicts each result when its request is
// taken in. Directed checks come first, then random predict/resolve traffic
// under several table settings. Both handshakes idle and stall at random.
// ============================================================================
module branch_direction_predictor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdp_pkg::*;

    localparam int COUNTER_SLOTS    = COUNTER_ENTRIES_DEF;
    localparam int HISTORY_SLOTS    = HISTORY_ENTRIES_DEF;
    localparam int HOT_PCS          = 12;
    localparam int LONG_HOLD_CYCLES = 400;
    // The table sweep after reset passes with no transfer.
    localparam int WATCHDOG_LIMIT   = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    bdp_in_t               in_data;
    logic                  out_valid;
    logic                  out_stall;
    bdp_out_t              out_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    branch_direction_predictor i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Model state: raw register values and table contents.
    bdp_mode_t   model_mode;
    logic [3:0]  model_ctr_width;
    logic [3:0]  model_hist_len;
    logic [3:0]  model_index_bits;
    logic [7:0]  counter_model [COUNTER_SLOTS];
    logic [7:0]  history_model [HISTORY_SLOTS];
    logic [9:0]  global_history_model;
    logic [31:0] branch_total;
    logic [31:0] correct_total;

    bdp_out_t    expected_results [$];
    int          mismatches;
    int          idle_cycles;
    bit          long_hold_pending;
    int          gapless_left;
    bdp_out_t    want;

    logic [47:0] hot_pcs [HOT_PCS];
    int          hot_kind [HOT_PCS];
    bit          hot_last [HOT_PCS];

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Works out the result of one request and advances the model tables.
    function automatic bdp_out_t predict_direction_result(bdp_in_t item);
        int unsigned cb;
        int unsigned hb;
        int unsigned ib;
        int unsigned cmax;
        int unsigned half;
        int unsigned hslot;
        int unsigned cslot;
        logic [63:0] pcv;
        logic [63:0] imask;
        logic [63:0] hmask;
        logic [63:0] idx;
        logic [7:0]  ctr;
        bdp_out_t    result;

        cb    = clamp_range(32'(model_ctr_width), 1, 8);
        hb    = clamp_range(32'(model_hist_len), 1, MAX_HISTORY_BITS_DEF);
        ib    = clamp_range(32'(model_index_bits), 1, PC_IDX_W);
        cmax  = (1 << cb) - 1;
        half  = 1 << (cb - 1);
        pcv   = {16'd0, item.pc};
        imask = (64'd1 << ib) - 64'd1;
        hmask = (64'd1 << hb) - 64'd1;
        hslot = 32'((pcv & imask) % HISTORY_SLOTS);

        case (model_mode)
            MODE_BIMODAL:   idx = pcv & imask;
            MODE_TWO_LEVEL: idx = {56'd0, history_model[hslot]} & hmask;
            MODE_LOCAL:     idx = ((pcv & imask) << hb) + ({56'd0, history_model[hslot]} & hmask);
            default:        idx = (pcv ^ {54'd0, global_history_model}) & imask;
        endcase
        cslot = 32'(idx % COUNTER_SLOTS);

        result = '0;
        if (item.req_type == REQ_PREDICT)
        begin
            if (branch_total != '1)
                branch_total++;
            result.prediction = (counter_model[cslot] >= half);
        end
        else
        begin
            if (item.actual_taken == item.predicted_taken && correct_total != '1)
                correct_total++;
            ctr = counter_model[cslot];
            // A counter left above the maximum by a narrower width snaps to it on a taken update.
            if (item.actual_taken)
                ctr = (ctr < cmax) ? ctr + 8'd1 : cmax[7:0];
            else if (ctr > 0)
                ctr = ctr - 8'd1;
            counter_model[cslot] = ctr;
            if (model_mode == MODE_TWO_LEVEL || model_mode == MODE_LOCAL)
                history_model[hslot] = {history_model[hslot][6:0], item.actual_taken};
            else if (model_mode == MODE_GSHARE)
                global_history_model = {global_history_model[8:0], item.actual_taken};
        end
        result.branch_count  = branch_total;
        result.correct_count = correct_total;
        return result;
    endfunction

    function automatic bdp_in_t make_request(logic req, logic [47:0] pc, logic actual,
                                             logic predicted);
        bdp_in_t item;
        item.req_type        = req;
        item.pc              = pc;
        item.actual_taken    = actual;
        item.predicted_taken = predicted;
        return item;
    endfunction

    function automatic logic [47:0] random_pc();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless_left > 0)
        begin
            gapless_left--;
            return 0;
        end
        if (r < 3)
        begin
            gapless_left = $urandom_range(20, 50);
            return 0;
        end
        if (r < 50)
            return 0;
        return gap_length();
    endfunction

    // Offers one request and waits for its transfer. The expected result is
    // queued at the edge that takes the request in.
    task automatic send_request(input bdp_in_t item, input bit paced, output bdp_out_t result);
        int gap;
        gap = paced ? sender_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        result = predict_direction_result(item);
        expected_results.push_back(result);
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input bdp_reg_t idx, input logic [3:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODE:      model_mode = bdp_mode_t'(value[1:0]);
            REG_CTR_WIDTH: model_ctr_width = value;
            REG_HIST_LEN:  model_hist_len = value;
            default:       model_index_bits = value;
        endcase
        @(posedge clk);
    endtask

    task automatic write_settings(input bdp_mode_t m, input logic [3:0] cb,
                                  input logic [3:0] hb, input logic [3:0] ib);
        // The upper data bits of the mode write are don't-care.
        write_register(REG_MODE, {2'($urandom_range(0, 3)), 2'(m)});
        write_register(REG_CTR_WIDTH, cb);
        write_register(REG_HIST_LEN, hb);
        write_register(REG_INDEX_BITS, ib);
    endtask

    // Reset settings: counters start weakly taken and saturate at zero.
    task automatic test_reset_state();
        bdp_out_t got;
        send_request(make_request(REQ_PREDICT, 48'h0, 1'b0, 1'b0), 1'b1, got);
        repeat (3)
            send_request(make_request(REQ_UPDATE, 48'h0, 1'b0, 1'b1), 1'b1, got);
        send_request(make_request(REQ_PREDICT, 48'h0, 1'b1, 1'b1), 1'b1, got);
        send_request(make_request(REQ_PREDICT, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0), 1'b1, got);
        finish_phase();
    endtask

    task automatic test_each_mode();
        bdp_out_t got;
        for (int m = 0; m < 4; m++)
        begin
            write_settings(bdp_mode_t'(m), 4'd2, 4'd2, 4'd10);
            send_request(make_request(REQ_UPDATE, 48'hAAAA_AAAA_AAAA, m[0], 1'b1), 1'b1, got);
            send_request(make_request(REQ_PREDICT, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0), 1'b1, got);
            finish_phase();
        end
    endtask

    // Out-of-range register values and the wrap of the local-mode index.
    task automatic test_register_limits();
        bdp_out_t got;
        write_settings(MODE_LOCAL, 4'd0, 4'd15, 4'd15);
        send_request(make_request(REQ_UPDATE, 48'h5555_5555_53FF, 1'b1, 1'b1), 1'b1, got);
        send_request(make_request(REQ_PREDICT, 48'h5555_5555_53FF, 1'b0, 1'b0), 1'b1, got);
        send_request(make_request(REQ_UPDATE, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1), 1'b1, got);
        send_request(make_request(REQ_PREDICT, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1), 1'b1, got);
        finish_phase();
        write_settings(MODE_TWO_LEVEL, 4'd15, 4'd0, 4'd0);
        send_request(make_request(REQ_UPDATE, 48'h8000_0000_0001, 1'b1, 1'b0), 1'b1, got);
        send_request(make_request(REQ_PREDICT, 48'h8000_0000_0001, 1'b0, 1'b1), 1'b1, got);
        send_request(make_request(REQ_UPDATE, 48'h0, 1'b0, 1'b0), 1'b1, got);
        send_request(make_request(REQ_PREDICT, 48'h0, 1'b1, 1'b0), 1'b1, got);
        finish_phase();
    endtask

    // A counter trained at a wide setting, then read and bumped at a narrow one.
    task automatic test_counter_width_change();
        bdp_out_t got;
        write_settings(MODE_BIMODAL, 4'd3, 4'd2, 4'd10);
        repeat (5)
            send_request(make_request(REQ_UPDATE, 48'h0000_0000_0123, 1'b1, 1'b1), 1'b1, got);
        finish_phase();
        write_register(REG_CTR_WIDTH, 4'd1);
        send_request(make_request(REQ_PREDICT, 48'h0000_0000_0123, 1'b0, 1'b0), 1'b1, got);
        send_request(make_request(REQ_UPDATE, 48'h0000_0000_0123, 1'b1, 1'b0), 1'b1, got);
        finish_phase();
        write_register(REG_CTR_WIDTH, 4'd3);
        send_request(make_request(REQ_PREDICT, 48'h0000_0000_0123, 1'b0, 1'b0), 1'b1, got);
        finish_phase();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        bdp_out_t got;
        write_settings(MODE_GSHARE, 4'd2, 4'd4, 4'd6);
        long_hold_pending = 1'b1;
        repeat (24)
            send_request(make_request(1'($urandom_range(0, 1)), random_pc(),
                                      1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1))), 1'b0, got);
        finish_phase();
    endtask

    // Predict/resolve pairs on a few hot branches, with random noise between.
    task automatic run_random_phase(input bdp_mode_t m, input logic [3:0] cb,
                                    input logic [3:0] hb, input logic [3:0] ib,
                                    input int count);
        bdp_out_t got;
        int       sent;
        int       k;
        bit       taken;
        write_settings(m, cb, hb, ib);
        for (int i = 0; i < HOT_PCS; i++)
        begin
            hot_pcs[i]  = random_pc();
            if (i < HOT_PCS / 2)
                hot_pcs[i][9:0] = 10'($urandom_range(0, 15));
            hot_kind[i] = $urandom_range(0, 2);
            hot_last[i] = 1'b0;
        end
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                k = $urandom_range(0, HOT_PCS - 1);
                send_request(make_request(REQ_PREDICT, hot_pcs[k], 1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1))), 1'b1, got);
                case (hot_kind[k])
                    0:       taken = ($urandom_range(0, 4) != 0);
                    1:       taken = ($urandom_range(0, 4) == 0);
                    default: taken = !hot_last[k];
                endcase
                hot_last[k] = taken;
                send_request(make_request(REQ_UPDATE, hot_pcs[k], taken, got.prediction),
                             1'b1, got);
                sent += 2;
            end
            else
            begin
                send_request(make_request(1'($urandom_range(0, 1)), random_pc(),
                                          1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1))), 1'b1, got);
                sent += 1;
            end
        end
        finish_phase();
    endtask

    task automatic test_random_traffic();
        run_random_phase(MODE_BIMODAL, 4'd2, 4'd2, 4'd10, 130);
        run_random_phase(MODE_TWO_LEVEL, 4'd8, 4'd8, 4'd10, 130);
        run_random_phase(MODE_LOCAL, 4'd1, 4'd1, 4'd1, 130);
        run_random_phase(MODE_GSHARE, 4'd8, 4'd1, 4'd10, 130);
        run_random_phase(MODE_LOCAL, 4'd3, 4'd8, 4'd10, 130);
        run_random_phase(MODE_TWO_LEVEL, 4'd2, 4'd3, 4'd4, 130);
        run_random_phase(MODE_GSHARE, 4'd4, 4'd4, 4'd3, 130);
        run_random_phase(bdp_mode_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
                         4'($urandom), 120);
        run_random_phase(bdp_mode_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
                         4'($urandom), 120);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        in_valid             = 1'b0;
        in_data              = '0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_wdata            = '0;
        mismatches           = 0;
        gapless_left         = 0;
        long_hold_pending    = 1'b0;
        model_mode           = MODE_BIMODAL;
        model_ctr_width      = 4'd2;
        model_hist_len       = 4'd2;
        model_index_bits     = 4'd10;
        global_history_model = '0;
        branch_total         = '0;
        correct_total        = '0;
        for (int i = 0; i < COUNTER_SLOTS; i++)
            counter_model[i] = CTR_RESET;
        for (int i = 0; i < HISTORY_SLOTS; i++)
            history_model[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_each_mode();
        test_register_limits();
        test_counter_width_change();
        test_output_backpressure();
        test_random_traffic();

        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: runs of stall and no stall, quiet stretches, and on request
    // one long hold-off.
    initial
    begin
        int  run_left;
        bit  level;
        out_stall = 1'b0;
        run_left  = 0;
        level     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                run_left = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if ($urandom_range(0, 99) < 10)
                    begin
                        level    = 1'b0;
                        run_left = $urandom_range(30, 80);
                    end
                    else
                    begin
                        level    = ($urandom_range(0, 2) == 0);
                        run_left = gap_length();
                    end
                end
                run_left--;
                out_stall <= level;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.prediction !== want.prediction)
                begin
                    $error("prediction: expected %0d, got %0d", want.prediction,
                           out_data.prediction);
                    mismatches++;
                end
                if (out_data.branch_count !== want.branch_count)
                begin
                    $error("branch_count: expected %0d, got %0d", want.branch_count,
                           out_data.branch_count);
                    mismatches++;
                end
                if (out_data.correct_count !== want.correct_count)
                begin
                    $error("correct_count: expected %0d, got %0d", want.correct_count,
                           out_data.correct_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
    end

endmodule

### sim.f
hw/rtl/bdp_pkg.sv
hw/rtl/bdp_front.sv
hw/rtl/bdp_back.sv
hw/rtl/branch_direction_predictor.sv
verif/branch_direction_predictor_test.sv
